// ===== hdl/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types and constants shared by the request head parser modules.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // One byte of request text, with its end-of-request mark.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last;
  } in_item_t;

  // Classification and status for one byte.
  typedef struct packed {
    logic [2:0] byte_class;
    logic [2:0] method_code;
    logic       error;
    logic       head_done;
    logic       valid_res;
  } out_item_t;

  // Parser phase. All eight codes are in use.
  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_VERSION = 3'd2,
    PH_HSTART  = 3'd3,
    PH_HNAME   = 3'd4,
    PH_HSKIP   = 3'd5,
    PH_HVALUE  = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  // Byte classes.
  localparam logic [2:0] CLS_METHOD  = 3'd0;
  localparam logic [2:0] CLS_URL     = 3'd1;
  localparam logic [2:0] CLS_VERSION = 3'd2;
  localparam logic [2:0] CLS_HNAME   = 3'd3;
  localparam logic [2:0] CLS_HVALUE  = 3'd4;
  localparam logic [2:0] CLS_DELIM   = 3'd5;

  // Method codes.
  localparam logic [2:0] MTH_UNKNOWN = 3'd0;
  localparam logic [2:0] MTH_GET     = 3'd1;
  localparam logic [2:0] MTH_POST    = 3'd2;
  localparam logic [2:0] MTH_CONNECT = 3'd3;
  localparam logic [2:0] MTH_PUT     = 3'd4;
  localparam logic [2:0] MTH_HEAD    = 3'd5;

  // Method names as big-endian ASCII, right aligned in 64 bits.
  localparam logic [63:0] TXT_GET     = 64'h0000_0000_0047_4554;
  localparam logic [63:0] TXT_POST    = 64'h0000_0000_504F_5354;
  localparam logic [63:0] TXT_CONNECT = 64'h0043_4F4E_4E45_4354;
  localparam logic [63:0] TXT_PUT     = 64'h0000_0000_0050_5554;
  localparam logic [63:0] TXT_HEAD    = 64'h0000_0000_4845_4144;

  // Special characters.
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  // Control bytes and bytes outside printable ASCII.
  function automatic logic bad_byte(input logic [7:0] b);
    return (b <= 8'd31) || (b >= 8'd127);
  endfunction

  // Punctuation that is not allowed in a header name.
  function automatic logic special_byte(input logic [7:0] b);
    return ((b >= 8'd33) && (b <= 8'd44)) || ((b >= 8'd46) && (b <= 8'd47)) ||
           ((b >= 8'd58) && (b <= 8'd64)) || ((b >= 8'd91) && (b <= 8'd96)) ||
           ((b >= 8'd123) && (b <= 8'd126));
  endfunction

endpackage

// ===== hdl/hrhp_core.sv =====
// ----------------------------------------------------------------------------
// hrhp_core
// Parser state and the per-byte update: classifies one byte, matches the
// method and tracks errors. State advances on each stepped item.
// ----------------------------------------------------------------------------
module hrhp_core #(
  parameter int MAX_METHOD_CHARS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  hrhp_pkg::in_item_t item,
  output hrhp_pkg::out_item_t res
);
  import hrhp_pkg::*;

  localparam int BUF_W = 8 * MAX_METHOD_CHARS;
  localparam int LEN_W = $clog2(MAX_METHOD_CHARS + 2);

  phase_t             phase, phase_next;
  logic [BUF_W-1:0]   method_buffer, method_buffer_next;
  logic [LEN_W-1:0]   method_length, method_length_next;
  logic [2:0]         method_found, method_found_next;
  logic               cr_pending, cr_pending_next;
  logic               failed, failed_next;
  logic               line_done, line_done_next;

  logic [7:0]         b;
  logic               is_cr;
  logic               is_lf;
  logic [2:0]         cls;
  logic [63:0]        buf_wide;
  logic [2:0]         decoded;

  assign b        = item.byte_in;
  assign is_cr    = (b == CH_CR);
  assign is_lf    = (b == CH_LF);
  assign buf_wide = 64'(method_buffer);

  // Method match on the collected name, used when the space arrives.
  always_comb begin
    if ((method_length == LEN_W'(3)) && (buf_wide == TXT_GET)) begin
      decoded = MTH_GET;
    end else if ((method_length == LEN_W'(4)) && (buf_wide == TXT_POST)) begin
      decoded = MTH_POST;
    end else if ((method_length == LEN_W'(7)) && (buf_wide == TXT_CONNECT)) begin
      decoded = MTH_CONNECT;
    end else if ((method_length == LEN_W'(3)) && (buf_wide == TXT_PUT)) begin
      decoded = MTH_PUT;
    end else if ((method_length == LEN_W'(4)) && (buf_wide == TXT_HEAD)) begin
      decoded = MTH_HEAD;
    end else begin
      decoded = MTH_UNKNOWN;
    end
  end

  // Per-byte state update and classification.
  always_comb begin
    phase_next         = phase;
    method_buffer_next = method_buffer;
    method_length_next = method_length;
    method_found_next  = method_found;
    failed_next        = failed;
    line_done_next     = line_done;
    cr_pending_next    = 1'b0;
    cls                = CLS_DELIM;

    // A carriage return must be followed by a line feed.
    if (cr_pending && !is_lf) begin
      failed_next = 1'b1;
    end

    unique case (phase)
      PH_METHOD: begin
        if (b == CH_SPACE) begin
          method_found_next = decoded;
          if (decoded == MTH_UNKNOWN) begin
            failed_next = 1'b1;
          end
          phase_next = PH_URL;
        end else begin
          cls = CLS_METHOD;
          if (method_length < LEN_W'(MAX_METHOD_CHARS)) begin
            method_buffer_next = {method_buffer[BUF_W-9:0], b};
            method_length_next = method_length + LEN_W'(1);
          end else begin
            method_length_next = LEN_W'(MAX_METHOD_CHARS + 1);
          end
        end
      end
      PH_URL: begin
        if (b == CH_SPACE) begin
          phase_next = PH_VERSION;
        end else begin
          cls = CLS_URL;
          if (bad_byte(b)) failed_next = 1'b1;
        end
      end
      PH_VERSION: begin
        if (is_cr) begin
          cr_pending_next = 1'b1;
        end else if (is_lf) begin
          line_done_next = 1'b1;
          phase_next     = PH_HSTART;
        end else begin
          cls = CLS_VERSION;
          if (bad_byte(b)) failed_next = 1'b1;
        end
      end
      PH_HSTART, PH_HNAME: begin
        if (is_cr && (phase == PH_HSTART)) begin
          cr_pending_next = 1'b1;
        end else if (is_lf) begin
          if (phase == PH_HSTART) begin
            phase_next = PH_DONE;
          end else begin
            // Header line ended without a colon.
            failed_next = 1'b1;
            phase_next  = PH_HSTART;
          end
        end else if (b == CH_COLON) begin
          phase_next = PH_HSKIP;
        end else begin
          cls = CLS_HNAME;
          if (bad_byte(b) || special_byte(b)) failed_next = 1'b1;
          phase_next = PH_HNAME;
        end
      end
      PH_HSKIP: begin
        // The byte after the colon is skipped unless it ends the line.
        if (is_cr) begin
          cr_pending_next = 1'b1;
          phase_next      = PH_HVALUE;
        end else if (is_lf) begin
          phase_next = PH_HSTART;
        end else begin
          phase_next = PH_HVALUE;
        end
      end
      PH_HVALUE: begin
        if (is_cr) begin
          cr_pending_next = 1'b1;
        end else if (is_lf) begin
          phase_next = PH_HSTART;
        end else begin
          cls = CLS_HVALUE;
          if (bad_byte(b)) failed_next = 1'b1;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // Result for this byte, taken from the updated state.
  always_comb begin
    res.byte_class  = cls;
    res.method_code = method_found_next;
    res.error       = failed_next;
    res.head_done   = (phase_next == PH_DONE);
    res.valid_res   = item.last && !failed_next && line_done_next;
  end

  // State registers; the final byte of a request returns them to reset.
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      phase         <= PH_METHOD;
      method_buffer <= '0;
      method_length <= '0;
      method_found  <= MTH_UNKNOWN;
      cr_pending    <= 1'b0;
      failed        <= 1'b0;
      line_done     <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      method_buffer <= method_buffer_next;
      method_length <= method_length_next;
      method_found  <= method_found_next;
      cr_pending    <= cr_pending_next;
      failed        <= failed_next;
      line_done     <= line_done_next;
    end
  end

endmodule

// ===== hdl/http_request_head_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_head_parser
// Byte-wide HTTP request head parser: labels each byte by field, decodes
// the method and reports errors, end of head and request acceptance.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   item      in         item_valid / item_ready    in_item_t  (byte_in, last)
//   result    out        result_valid / result_ready out_item_t (one per byte)
//
// One byte per cycle is sustained while result_ready is held high; a byte
// is accepted into the input register, then moves to the result register.
// The single-pass update between these registers sets the rate.
// Reset clears both valid flags and all parser state.
// A stalled result holds its register; the input register still takes a
// byte while the result waits, after which item_ready drops.
//
module http_request_head_parser #(
  parameter int MAX_METHOD_CHARS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  hrhp_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output hrhp_pkg::out_item_t result
);
  import hrhp_pkg::*;

  logic      held_valid;
  in_item_t  held_item;
  logic      advance;
  out_item_t step_res;

  // The held byte moves on when the result register is free or draining.
  assign advance    = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held_item <= item;
    end
  end

  // Parser state and per-byte logic.
  hrhp_core #(
    .MAX_METHOD_CHARS(MAX_METHOD_CHARS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (held_item),
    .res  (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

endmodule

// ===== hdl/hrhp_checker.sv =====
// ----------------------------------------------------------------------------
// hrhp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hrhp_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input hrhp_pkg::out_item_t result
);
  import hrhp_pkg::*;

  // No result is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result shown straight after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // An accepted request never carries an error.
  a_valid_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.valid_res) |-> !result.error)
    else $error("accepted request flagged as malformed");

  // Once the head is complete, every byte is a delimiter or ignored.
  a_done_delim: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.head_done) |-> (result.byte_class == CLS_DELIM))
    else $error("field byte reported after end of head");

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
